// ===== sv/ring_fifo_burst_dequeue_macros.svh =====
// Assertion macros for the ring FIFO with burst dequeue.
`ifndef RING_FIFO_BURST_DEQUEUE_MACROS_SVH
`define RING_FIFO_BURST_DEQUEUE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define RFBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define RFBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rfbd_pkg.sv =====
// Package: sizes, status codes and beat types of the ring FIFO with burst dequeue.
package rfbd_pkg;

    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam int WORD_W  = 64;
    localparam int WANT_W  = 5;
    localparam int PTR_W   = $clog2(2 * DEPTH);
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TAKE_W  = $clog2(MAX_RESULTS + 1);
    localparam int CMP_A_W = (CNT_W > WANT_W) ? CNT_W : WANT_W;
    localparam int CMP_W   = (CMP_A_W > TAKE_W) ? CMP_A_W : TAKE_W;
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_ENQ  = 2'd0,
        ST_FULL = 2'd1,
        ST_POP  = 2'd2,
        ST_NONE = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [WORD_W-1:0]  push_word;
        logic [WANT_W-1:0]  want_count;
    } req_beat_t;

    typedef struct packed {
        status_t            status;
        logic [WORD_W-1:0]  pop_word;
        logic               last;
    } rsp_beat_t;

    typedef struct packed {
        status_t            status;
        logic [WORD_W-1:0]  word;
        logic [TAKE_W-1:0]  take;
        logic [IDX_W-1:0]   idx;
    } op_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } queue_status_t;

endpackage

// ===== sv/rfbd_front.sv =====
// Front end: accept request beats, track pointers, classify into queued operations.
module rfbd_front
    import rfbd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  req_beat_t     req_data,
    input  queue_status_t q_status,
    output logic          push,
    output op_t           push_op
);

    localparam logic [PTR_W:0] PTR_MOD = (PTR_W + 1)'(2 * DEPTH);

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    stored_wide;
    logic [CNT_W-1:0]  stored;
    logic              is_full;
    logic [CMP_W-1:0]  want_e, have_e, max_e, take_e;
    logic [TAKE_W-1:0] take;
    logic [PTR_W:0]    rd_sum;
    logic              accept;

    function automatic logic [IDX_W-1:0] slot_of(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        begin
            q = (p >= PTR_W'(DEPTH)) ? p - PTR_W'(DEPTH) : p;
            return q[IDX_W-1:0];
        end
    endfunction

    assign req_stall = q_status.full;
    assign accept    = req_valid && !q_status.full;
    assign push      = accept;

    always_comb
    begin
        stored_wide = {1'b0, wr_ptr_reg} + ((wr_ptr_reg < rd_ptr_reg) ? PTR_MOD : '0)
                    - {1'b0, rd_ptr_reg};
        stored  = stored_wide[CNT_W-1:0];
        is_full = (stored == CNT_W'(DEPTH));

        want_e = CMP_W'(req_data.want_count);
        have_e = CMP_W'(stored);
        max_e  = CMP_W'(MAX_RESULTS);
        take_e = (want_e < have_e) ? want_e : have_e;
        take_e = (take_e < max_e) ? take_e : max_e;
        take   = take_e[TAKE_W-1:0];

        rd_sum = {1'b0, rd_ptr_reg} + (PTR_W + 1)'(take);
        if (rd_sum >= PTR_MOD)
        begin
            rd_sum = rd_sum - PTR_MOD;
        end

        push_op.word = req_data.push_word;
        push_op.take = take;
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;

        if (req_data.cmd == CMD_ENQ)
        begin
            push_op.idx = slot_of(wr_ptr_reg);
            if (is_full)
            begin
                push_op.status = ST_FULL;
            end
            else
            begin
                push_op.status = ST_ENQ;
                wr_ptr_next = (wr_ptr_reg == PTR_W'(2 * DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
        end
        else
        begin
            push_op.idx = slot_of(rd_ptr_reg);
            if (take == '0)
            begin
                push_op.status = ST_NONE;
            end
            else
            begin
                push_op.status = ST_POP;
                rd_ptr_next = rd_sum[PTR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else if (accept)
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

// ===== sv/rfbd_queue.sv =====
// Short operation queue between the front end and the back end.
module rfbd_queue
    import rfbd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  op_t           push_op,
    input  logic          pop,
    output queue_status_t q_status,
    output op_t           head_op
);

    op_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign q_status.full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.head_valid = (cnt_reg != '0);
    assign head_op             = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_op;
        end
    end

endmodule

// ===== sv/rfbd_back.sv =====
// Back end: slot store, burst sequencer and output register.
module rfbd_back
    import rfbd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  op_t           head_op,
    output logic          pop,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rsp_beat_t     rsp_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [TAKE_W-1:0] beat_reg, beat_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  cur_idx;
    logic              out_valid_reg, out_valid_next;
    rsp_beat_t         out_reg;
    logic              load;
    logic              fire;
    logic              last_beat;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    always_comb
    begin
        load      = !out_valid_reg || !rsp_stall;
        fire      = q_status.head_valid && load;
        last_beat = (head_op.status != ST_POP) || (beat_reg + 1'b1 == head_op.take);
        pop       = fire && last_beat;
        cur_idx   = (beat_reg == '0) ? head_op.idx : idx_reg;

        beat_next      = beat_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            beat_next      = last_beat ? '0 : beat_reg + 1'b1;
            idx_next       = (cur_idx == IDX_W'(DEPTH - 1)) ? '0 : cur_idx + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (load)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            beat_reg      <= beat_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && head_op.status == ST_ENQ)
        begin
            mem[head_op.idx] <= head_op.word;
        end
        if (fire)
        begin
            out_reg.status   <= head_op.status;
            out_reg.last     <= last_beat;
            out_reg.pop_word <= (head_op.status == ST_POP) ? mem[cur_idx] : '0;
        end
    end

endmodule

// ===== sv/ring_fifo_burst_dequeue.sv =====
// Top level: ring FIFO of 64-bit words with single-word enqueue and burst dequeue.
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------
//  request | req_valid / req_stall     | req_data: cmd, push_word, want_count
//  result  | rsp_valid / rsp_stall     | rsp_data: status, pop_word, last
//
//  Enqueue, full reject and empty/zero dequeue: one result beat each.
//  Dequeue of n words: n beats; the back end reads one slot per cycle unless stalled.
//  A taken request waits in the operation queue; its first result beat is then registered.
//  Reset clears the pointers and the operation queue; the slot store is not cleared.
//  rsp_stall holds the output register; the two-entry queue then fills and raises req_stall.
module ring_fifo_burst_dequeue
    import rfbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_beat_t req_data,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp_data
);

    queue_status_t q_status;
    logic          push;
    op_t           push_op;
    logic          pop;
    op_t           head_op;

    rfbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .q_status  (q_status),
        .push      (push),
        .push_op   (push_op)
    );

    rfbd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .pop      (pop),
        .q_status (q_status),
        .head_op  (head_op)
    );

    rfbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_op   (head_op),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

// ===== sv/rfbd_checker.sv =====
// Port checker for the ring FIFO with burst dequeue, bound to the top level.
`include "ring_fifo_burst_dequeue_macros.svh"

module rfbd_checker
    import rfbd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_beat_t rsp_data
);

    logic held;
    logic non_pop;

    assign held    = rsp_valid && rsp_stall;
    assign non_pop = rsp_valid && (rsp_data.status != ST_POP);

    `RFBD_ASSERT_NEXT(a_rsp_hold, held, rsp_valid && $stable(rsp_data), "stalled beat changed")
    `RFBD_ASSERT_NOW(a_word_zero, non_pop, rsp_data.pop_word == '0, "word on a non-dequeue beat")
    `RFBD_ASSERT_NOW(a_single_last, non_pop, rsp_data.last, "single-beat result without last")

endmodule

bind ring_fifo_burst_dequeue rfbd_checker u_rfbd_checker (.*);
